// File: sv/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, character constants and decode functions for the infix to
// postfix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

   // character and stack entry widths
   localparam int CHAR_W = 8;
   localparam int CODE_W = 3;

   // special characters of the infix stream
   localparam logic [CHAR_W-1:0] CHAR_END  = 8'h23;  // '#'
   localparam logic [CHAR_W-1:0] CHAR_LPAR = 8'h28;  // '('
   localparam logic [CHAR_W-1:0] CHAR_RPAR = 8'h29;  // ')'
   localparam logic [CHAR_W-1:0] CHAR_MUL  = 8'h2A;  // '*'
   localparam logic [CHAR_W-1:0] CHAR_ADD  = 8'h2B;  // '+'
   localparam logic [CHAR_W-1:0] CHAR_SUB  = 8'h2D;  // '-'
   localparam logic [CHAR_W-1:0] CHAR_DIV  = 8'h2F;  // '/'

   // stack entry codes
   typedef enum logic [CODE_W-1:0] {
      CODE_MARK = 3'd0,
      CODE_LPAR = 3'd1,
      CODE_ADD  = 3'd2,
      CODE_SUB  = 3'd3,
      CODE_MUL  = 3'd4,
      CODE_DIV  = 3'd5
   } stack_code_type;

   // status codes carried by a result
   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_OVERFLOW  = 2'd1,
      ERR_UNMATCHED = 2'd2
   } err_type;

   // payload of one result before the last and done flags are known
   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              char_valid;
      err_type           error_code;
   } rsp_data_type;

   // operator precedence, zero for the bottom marker and '('
   function automatic logic [1:0] code_prec(stack_code_type code);
      logic [1:0] p;
      case (code)
         CODE_ADD, CODE_SUB: p = 2'd1;
         CODE_MUL, CODE_DIV: p = 2'd2;
         default:            p = 2'd0;
      endcase
      return p;
   endfunction

   // character emitted for a popped operator
   function automatic logic [CHAR_W-1:0] code_char(stack_code_type code);
      logic [CHAR_W-1:0] ch;
      case (code)
         CODE_LPAR: ch = CHAR_LPAR;
         CODE_ADD:  ch = CHAR_ADD;
         CODE_SUB:  ch = CHAR_SUB;
         CODE_MUL:  ch = CHAR_MUL;
         CODE_DIV:  ch = CHAR_DIV;
         default:   ch = '0;
      endcase
      return ch;
   endfunction

   // stack code of an operator character
   function automatic stack_code_type op_code(logic [CHAR_W-1:0] ch);
      stack_code_type c;
      case (ch)
         CHAR_ADD: c = CODE_ADD;
         CHAR_SUB: c = CODE_SUB;
         CHAR_MUL: c = CODE_MUL;
         default:  c = CODE_DIV;
      endcase
      return c;
   endfunction

endpackage

// File: sv/itp_req_if.sv
// ----------------------------------------------------------------------------
// itp_req_if
// Input channel: one infix character per transfer.
// ----------------------------------------------------------------------------
interface itp_req_if import itp_pkg::*; ();

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] in_char;

   modport source (output valid, output in_char, input ready);
   modport sink   (input valid, input in_char, output ready);

endinterface

// File: sv/itp_rsp_if.sv
// ----------------------------------------------------------------------------
// itp_rsp_if
// Result channel: one postfix character or status per transfer.
// ----------------------------------------------------------------------------
interface itp_rsp_if import itp_pkg::*; ();

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] out_char;
   logic              char_valid;
   logic              last;
   logic              expr_done;
   logic [1:0]        error_code;

   modport source (output valid, output out_char, output char_valid, output last,
                   output expr_done, output error_code, input ready);
   modport sink   (input valid, input out_char, input char_valid, input last,
                   input expr_done, input error_code, output ready);

endinterface

// File: sv/itp_ram.sv
// ----------------------------------------------------------------------------
// itp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module itp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard conversion of an infix character stream into postfix, with
// the operator stack held in a RAM and its top cached in a register.
// ----------------------------------------------------------------------------
// One character is taken per transfer. While idle, the first character opens
// an expression and gives no result. An operand, a push of '(' or of an
// operator, or an error status is accepted and then evaluated. Every pop
// reads the new top from the stack RAM, whose read port is registered, and
// loads it before the next decision. A final result left in the hold stage
// is released from a flush state. Results leave through an output register
// and a one-entry hold stage that marks the final result of each item; a
// result waiting on a stalled output channel holds the sequencer in place.
// The stack holds STACK_DEPTH entries, the bottom marker included; a push
// onto a full stack is dropped and reported as overflow.
module infix_to_postfix_converter import itp_pkg::*; #(
   parameter int STACK_DEPTH = 64
) (
   input  logic      clock,
   input  logic      reset,
   itp_req_if.sink   req_bus,
   itp_rsp_if.source rsp_bus
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_EVAL  = 4'b0010,
      S_READ  = 4'b0100,
      S_FLUSH = 4'b1000
   } state_type;

   state_type         state_ff,    state_in;
   logic              open_ff,     open_in;
   logic [CW-1:0]     count_ff,    count_in;
   stack_code_type    top_ff,      top_in;
   logic [CHAR_W-1:0] char_ff,     char_in;
   logic              stop_ff,     stop_in;
   logic              pend_vld_ff, pend_vld_in;
   rsp_data_type      pend_ff,     pend_in;
   logic              out_vld_ff,  out_vld_in;
   rsp_data_type      out_ff,      out_in;
   logic              out_last_ff, out_last_in;
   logic              out_done_ff, out_done_in;

   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [CODE_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [CODE_W-1:0] ram_rd_data;

   logic              out_free;
   logic              req_xfer;
   logic              is_end, is_lpar, is_rpar, is_op;
   stack_code_type    new_code;
   logic              stack_full;
   logic [CW-1:0]     count_m1, count_m2;

   // per-step decision in the evaluate state
   logic              do_pop, do_push, term, r_vld, fire;
   rsp_data_type      r_data;

   itp_ram #(
      .WIDTH (CODE_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // character classes and stack arithmetic
   assign is_end     = (char_ff == CHAR_END);
   assign is_lpar    = (char_ff == CHAR_LPAR);
   assign is_rpar    = (char_ff == CHAR_RPAR);
   assign is_op      = (char_ff == CHAR_ADD) || (char_ff == CHAR_SUB) ||
                       (char_ff == CHAR_MUL) || (char_ff == CHAR_DIV);
   assign new_code   = is_lpar ? CODE_LPAR : op_code(char_ff);
   assign stack_full = (count_ff >= CW'(STACK_DEPTH));
   assign count_m1   = count_ff - CW'(1);
   assign count_m2   = count_ff - CW'(2);

   assign out_free = !out_vld_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_xfer = req_bus.valid && req_bus.ready;

   // shunting-yard step on the cached stack top
   always_comb begin
      do_pop  = 1'b0;
      do_push = 1'b0;
      term    = 1'b0;
      r_vld   = 1'b0;
      r_data  = '{out_char: '0, char_valid: 1'b0, error_code: ERR_NONE};
      if (is_end) begin
         if (top_ff != CODE_MARK) begin
            do_pop = 1'b1;
            if (top_ff != CODE_LPAR) begin
               r_vld  = 1'b1;
               r_data = '{out_char: code_char(top_ff), char_valid: 1'b1,
                          error_code: ERR_NONE};
            end
         end else begin
            term  = 1'b1;
            r_vld = !pend_vld_ff;
         end
      end else if (is_rpar) begin
         if (top_ff == CODE_MARK) begin
            term   = 1'b1;
            r_vld  = 1'b1;
            r_data.error_code = ERR_UNMATCHED;
         end else if (top_ff == CODE_LPAR) begin
            do_pop = 1'b1;
         end else begin
            do_pop = 1'b1;
            r_vld  = 1'b1;
            r_data = '{out_char: code_char(top_ff), char_valid: 1'b1,
                       error_code: ERR_NONE};
         end
      end else if (is_op && code_prec(top_ff) != 2'd0 &&
                   code_prec(top_ff) >= code_prec(new_code)) begin
         do_pop = 1'b1;
         r_vld  = 1'b1;
         r_data = '{out_char: code_char(top_ff), char_valid: 1'b1,
                    error_code: ERR_NONE};
      end else if (is_op || is_lpar) begin
         term = 1'b1;
         if (stack_full) begin
            r_vld = 1'b1;
            r_data.error_code = ERR_OVERFLOW;
         end else begin
            do_push = 1'b1;
         end
      end else begin
         term   = 1'b1;
         r_vld  = 1'b1;
         r_data = '{out_char: char_ff, char_valid: 1'b1, error_code: ERR_NONE};
      end
      // a result that must go to the output register waits for a free slot
      fire = !(r_vld && (pend_vld_ff || term) && !out_free);
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      open_in     = open_ff;
      count_in    = count_ff;
      top_in      = top_ff;
      char_in     = char_ff;
      stop_in     = stop_ff;
      pend_vld_in = pend_vld_ff;
      pend_in     = pend_ff;
      out_vld_in  = out_vld_ff && !rsp_bus.ready;
      out_in      = out_ff;
      out_last_in = out_last_ff;
      out_done_in = out_done_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = count_ff[AW-1:0];
      ram_wr_data = CODE_W'(new_code);
      ram_rd_en   = 1'b0;
      ram_rd_addr = count_m2[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               if (!open_ff) begin
                  // opening character lays down the bottom marker
                  open_in     = 1'b1;
                  count_in    = CW'(1);
                  top_in      = CODE_MARK;
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = '0;
                  ram_wr_data = CODE_W'(CODE_MARK);
               end else begin
                  char_in  = req_bus.in_char;
                  stop_in  = 1'b0;
                  state_in = S_EVAL;
               end
            end
         end

         S_EVAL: begin
            if (fire) begin
               // route the new result to the output register or through the hold stage
               if (r_vld) begin
                  if (pend_vld_ff) begin
                     out_vld_in  = 1'b1;
                     out_in      = pend_ff;
                     out_last_in = 1'b0;
                     out_done_in = 1'b0;
                     pend_in     = r_data;
                  end else if (term) begin
                     out_vld_in  = 1'b1;
                     out_in      = r_data;
                     out_last_in = 1'b1;
                     out_done_in = is_end;
                  end else begin
                     pend_vld_in = 1'b1;
                     pend_in     = r_data;
                  end
               end
               if (do_pop) begin
                  count_in  = count_m1;
                  ram_rd_en = 1'b1;
                  stop_in   = is_rpar && (top_ff == CODE_LPAR);
                  state_in  = S_READ;
               end else begin
                  if (do_push) begin
                     ram_wr_en = 1'b1;
                     top_in    = new_code;
                     count_in  = count_ff + CW'(1);
                  end
                  if (is_end) begin
                     open_in  = 1'b0;
                     count_in = '0;
                  end
                  state_in = (pend_vld_ff || pend_vld_in) ? S_FLUSH : S_IDLE;
               end
            end
         end

         S_READ: begin
            top_in   = stack_code_type'(ram_rd_data);
            state_in = stop_ff ? S_FLUSH : S_EVAL;
         end

         S_FLUSH: begin
            // release the held result as the final one of the item
            if (!pend_vld_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_vld_in  = 1'b1;
               out_in      = pend_ff;
               out_last_in = 1'b1;
               out_done_in = is_end;
               pend_vld_in = 1'b0;
               state_in    = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         open_ff     <= 1'b0;
         count_ff    <= '0;
         stop_ff     <= 1'b0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         open_ff     <= open_in;
         count_ff    <= count_in;
         stop_ff     <= stop_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      top_ff      <= top_in;
      char_ff     <= char_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
      out_done_ff <= out_done_in;
   end

   // result channel
   assign rsp_bus.valid      = out_vld_ff;
   assign rsp_bus.out_char   = out_ff.out_char;
   assign rsp_bus.char_valid = out_ff.char_valid;
   assign rsp_bus.error_code = out_ff.error_code;
   assign rsp_bus.last       = out_last_ff;
   assign rsp_bus.expr_done  = out_done_ff;

endmodule

// File: sim/infix_to_postfix_converter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_tb
// Self-checking bench for the shunting-yard infix to postfix converter. A
// directed table walks the corner cases (opening character, empty flush,
// unmatched ')', stack overflow, precedence pops), then random expressions
// with some noise follow. A behavioral shunting-yard model predicts the
// untyped rows' results; all are compared field by field on the result channel.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_tb import itp_pkg::*; ();

   localparam int STACK_DEPTH     = 64;
   localparam int RANDOM_ITEMS    = 280;
   localparam int TAIL_ITEMS      = 60;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int HOLD_OFF_AFTER  = 60;
   localparam int DRAIN_CYCLES    = 200;
   localparam int STALL_LIMIT     = 3000;

   // one postfix result as seen on the result channel
   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              char_valid;
      logic              last;
      logic              expr_done;
      err_type           error_code;
   } postfix_result_type;

   // one infix character, optionally with a hand-written expectation
   typedef struct {
      logic [CHAR_W-1:0]  ch;
      int                 reps;
      bit                 typed;
      bit                 has_res;
      postfix_result_type res;
   } infix_row_type;

   localparam postfix_result_type NO_RES    = '{8'h00, 1'b0, 1'b0, 1'b0, ERR_NONE};
   localparam postfix_result_type EMPTY_END = '{8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE};
   localparam postfix_result_type UNMATCHED = '{8'h00, 1'b0, 1'b1, 1'b0, ERR_UNMATCHED};
   localparam postfix_result_type OVERFLOW  = '{8'h00, 1'b0, 1'b1, 1'b0, ERR_OVERFLOW};

   // directed walk: typed rows are read straight off the spec
   localparam int N_ROWS = 26;
   infix_row_type directed_rows [N_ROWS] = '{
      '{8'h41,     1,  1'b1, 1'b0, NO_RES},    // 'A' only opens
      '{CHAR_END,  1,  1'b1, 1'b1, EMPTY_END}, // empty flush
      '{CHAR_END,  1,  1'b1, 1'b0, NO_RES},    // '#' as opening char
      '{CHAR_RPAR, 1,  1'b1, 1'b1, UNMATCHED},
      '{8'h00,     1,  1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0, ERR_NONE}},
      '{8'hFF,     1,  1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0, ERR_NONE}},
      '{8'h61,     1,  1'b0, 1'b0, NO_RES},
      '{CHAR_ADD,  1,  1'b0, 1'b0, NO_RES},
      '{8'h62,     1,  1'b0, 1'b0, NO_RES},
      '{CHAR_MUL,  1,  1'b0, 1'b0, NO_RES},
      '{8'h63,     1,  1'b0, 1'b0, NO_RES},
      '{CHAR_SUB,  1,  1'b0, 1'b0, NO_RES},    // pops '*' then '+'
      '{CHAR_LPAR, 1,  1'b0, 1'b0, NO_RES},
      '{8'h64,     1,  1'b0, 1'b0, NO_RES},
      '{CHAR_DIV,  1,  1'b0, 1'b0, NO_RES},
      '{8'h65,     1,  1'b0, 1'b0, NO_RES},
      '{CHAR_RPAR, 1,  1'b0, 1'b0, NO_RES},
      '{CHAR_LPAR, 1,  1'b0, 1'b0, NO_RES},    // left open at the flush
      '{CHAR_END,  1,  1'b0, 1'b0, NO_RES},
      '{8'h78,     1,  1'b1, 1'b0, NO_RES},    // opens
      '{CHAR_LPAR, STACK_DEPTH-1, 1'b0, 1'b0, NO_RES}, // fills the stack
      '{CHAR_LPAR, 1,  1'b1, 1'b1, OVERFLOW},
      '{CHAR_ADD,  1,  1'b1, 1'b1, OVERFLOW},
      '{CHAR_RPAR, STACK_DEPTH-1, 1'b0, 1'b0, NO_RES},
      '{CHAR_RPAR, 1,  1'b1, 1'b1, UNMATCHED},
      '{CHAR_END,  1,  1'b1, 1'b1, EMPTY_END}
   };

   logic clock = 1'b0;
   logic reset;

   itp_req_if req_bus ();
   itp_rsp_if rsp_bus ();

   infix_to_postfix_converter #(
      .STACK_DEPTH (STACK_DEPTH)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // shunting-yard model
   // ------------------------------------------------------------------------
   bit                 infix_open;
   stack_code_type     op_stack [STACK_DEPTH];
   int                 op_count;
   postfix_result_type step_postfix [$];
   postfix_result_type postfix_expected [$];

   infix_row_type      infix_feed [$];
   int                 fail_count;
   int                 results_seen;
   bit                 tail_phase;

   function automatic stack_code_type stack_top();
      if (op_count == 0)
         return CODE_MARK;
      return op_stack[op_count-1];
   endfunction

   function automatic int rank(stack_code_type code);
      if (code == CODE_ADD || code == CODE_SUB)
         return 1;
      if (code == CODE_MUL || code == CODE_DIV)
         return 2;
      return 0;
   endfunction

   function automatic logic [CHAR_W-1:0] op_symbol(stack_code_type code);
      case (code)
         CODE_ADD: return CHAR_ADD;
         CODE_SUB: return CHAR_SUB;
         CODE_MUL: return CHAR_MUL;
         CODE_DIV: return CHAR_DIV;
         default:  return 8'h00;
      endcase
   endfunction

   function automatic bit push_op(stack_code_type code);
      if (op_count >= STACK_DEPTH)
         return 1'b0;
      op_stack[op_count] = code;
      op_count++;
      return 1'b1;
   endfunction

   function automatic void add_postfix(logic [CHAR_W-1:0] ch, logic vld, err_type err);
      postfix_result_type r;
      r = '{ch, vld, 1'b0, 1'b0, err};
      step_postfix.push_back(r);
   endfunction

   // results caused by one infix character, left in step_postfix
   function automatic void convert_char(logic [CHAR_W-1:0] c);
      stack_code_type t;
      stack_code_type code;
      bit             ended;
      int             n;
      step_postfix.delete();
      ended = 1'b0;
      if (!infix_open) begin
         infix_open = 1'b1;
         op_count   = 0;
         void'(push_op(CODE_MARK));
         return;
      end
      case (c)
         CHAR_END: begin
            while (stack_top() != CODE_MARK) begin
               t = stack_top();
               op_count--;
               if (t != CODE_LPAR)
                  add_postfix(op_symbol(t), 1'b1, ERR_NONE);
            end
            if (step_postfix.size() == 0)
               add_postfix(8'h00, 1'b0, ERR_NONE);
            infix_open = 1'b0;
            op_count   = 0;
            ended      = 1'b1;
         end
         CHAR_LPAR: begin
            if (!push_op(CODE_LPAR))
               add_postfix(8'h00, 1'b0, ERR_OVERFLOW);
         end
         CHAR_RPAR: begin
            forever begin
               t = stack_top();
               if (t == CODE_MARK) begin
                  add_postfix(8'h00, 1'b0, ERR_UNMATCHED);
                  break;
               end
               op_count--;
               if (t == CODE_LPAR)
                  break;
               add_postfix(op_symbol(t), 1'b1, ERR_NONE);
            end
         end
         CHAR_ADD, CHAR_SUB, CHAR_MUL, CHAR_DIV: begin
            case (c)
               CHAR_ADD: code = CODE_ADD;
               CHAR_SUB: code = CODE_SUB;
               CHAR_MUL: code = CODE_MUL;
               default:  code = CODE_DIV;
            endcase
            while (rank(stack_top()) != 0 && rank(stack_top()) >= rank(code)) begin
               t = stack_top();
               op_count--;
               add_postfix(op_symbol(t), 1'b1, ERR_NONE);
            end
            if (!push_op(code))
               add_postfix(8'h00, 1'b0, ERR_OVERFLOW);
         end
         default: add_postfix(c, 1'b1, ERR_NONE);
      endcase
      n = step_postfix.size();
      if (n > 0) begin
         step_postfix[n-1].last = 1'b1;
         if (ended)
            step_postfix[n-1].expr_done = 1'b1;
      end
   endfunction

   // ------------------------------------------------------------------------
   // stimulus generation
   // ------------------------------------------------------------------------
   function automatic bit is_special(logic [CHAR_W-1:0] c);
      return c == CHAR_END || c == CHAR_LPAR || c == CHAR_RPAR || c == CHAR_ADD ||
             c == CHAR_SUB || c == CHAR_MUL || c == CHAR_DIV;
   endfunction

   function automatic logic [CHAR_W-1:0] rand_operand();
      logic [CHAR_W-1:0] c;
      do
         c = CHAR_W'($urandom_range(0, 255));
      while (is_special(c));
      return c;
   endfunction

   function automatic logic [CHAR_W-1:0] rand_operator();
      case ($urandom_range(0, 3))
         0:       return CHAR_ADD;
         1:       return CHAR_SUB;
         2:       return CHAR_MUL;
         default: return CHAR_DIV;
      endcase
   endfunction

   function automatic void feed_char(logic [CHAR_W-1:0] c);
      infix_row_type row;
      row = '{c, 1, 1'b0, 1'b0, NO_RES};
      infix_feed.push_back(row);
   endfunction

   // one mostly well-formed expression, with occasional noise and deep nesting
   function automatic void add_expression();
      int opens;
      int terms;
      int k;
      bit want_operand;
      opens        = 0;
      want_operand = 1'b1;
      terms        = $urandom_range(1, 12);
      feed_char(CHAR_W'($urandom_range(0, 255)));   // opening character
      if ($urandom_range(0, 19) == 0) begin
         k = $urandom_range(STACK_DEPTH-4, STACK_DEPTH+4);
         repeat (k) feed_char(CHAR_LPAR);
         opens += k;
      end
      repeat (terms) begin
         if ($urandom_range(0, 14) == 0)
            feed_char(CHAR_W'($urandom_range(0, 255)));
         if (want_operand) begin
            if ($urandom_range(0, 9) < 3 && opens < 20) begin
               feed_char(CHAR_LPAR);
               opens++;
            end else begin
               feed_char(rand_operand());
               want_operand = 1'b0;
            end
         end else if ($urandom_range(0, 9) < 2 && opens > 0) begin
            feed_char(CHAR_RPAR);
            opens--;
         end else begin
            feed_char(rand_operator());
            want_operand = 1'b1;
         end
      end
      if (want_operand)
         feed_char(rand_operand());
      if ($urandom_range(0, 3) != 0)
         repeat (opens) feed_char(CHAR_RPAR);
      feed_char(CHAR_END);
   endfunction

   // ------------------------------------------------------------------------
   // input side: reset, then walk the feed with random gaps
   // ------------------------------------------------------------------------
   initial begin : infix_driver
      infix_row_type item;
      int            directed_len;
      bit            calm;
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.in_char <= '0;
      infix_open   = 1'b0;
      op_count     = 0;
      fail_count   = 0;
      tail_phase   = 1'b0;
      calm         = 1'b0;

      foreach (directed_rows[r]) begin
         item = directed_rows[r];
         repeat (item.reps) infix_feed.push_back(item);
      end
      directed_len = infix_feed.size();
      while (infix_feed.size() - directed_len < RANDOM_ITEMS)
         add_expression();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (infix_feed[i]) begin
         item = infix_feed[i];
         if (i >= infix_feed.size() - TAIL_ITEMS)
            tail_phase = 1'b1;
         if (i % 32 == 0)
            calm = ($urandom_range(0, 2) == 0);
         if (!tail_phase && !calm && $urandom_range(0, 3) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         req_bus.valid   <= 1'b1;
         req_bus.in_char <= item.ch;
         do
            @(posedge clock);
         while (!req_bus.ready);
         // transfer accepted at this edge
         convert_char(item.ch);
         if (item.typed) begin
            if (item.has_res)
               postfix_expected.push_back(item.res);
         end else begin
            foreach (step_postfix[j])
               postfix_expected.push_back(step_postfix[j]);
         end
      end
      req_bus.valid <= 1'b0;

      while (postfix_expected.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("PASS infix_to_postfix_converter");
      else
         $display("FAIL infix_to_postfix_converter");
      $finish;
   end

   // ------------------------------------------------------------------------
   // result side: random stalls, one long hold-off to back up the block
   // ------------------------------------------------------------------------
   initial begin : postfix_receiver
      bit held_off;
      bit calm;
      held_off = 1'b0;
      calm     = 1'b0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if ($urandom_range(0, 49) == 0)
            calm = !calm;
         if (!held_off && results_seen >= HOLD_OFF_AFTER) begin
            held_off = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else if (!tail_phase && !calm && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin : postfix_check
      postfix_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (postfix_expected.size() == 0) begin
            $error("unexpected result: out_char %h char_valid %b error_code %0d",
                   rsp_bus.out_char, rsp_bus.char_valid, rsp_bus.error_code);
            fail_count++;
         end else begin
            want = postfix_expected.pop_front();
            if (rsp_bus.out_char !== want.out_char) begin
               $error("out_char: expected %h, got %h", want.out_char, rsp_bus.out_char);
               fail_count++;
            end
            if (rsp_bus.char_valid !== want.char_valid) begin
               $error("char_valid: expected %b, got %b", want.char_valid, rsp_bus.char_valid);
               fail_count++;
            end
            if (rsp_bus.last !== want.last) begin
               $error("last: expected %b, got %b", want.last, rsp_bus.last);
               fail_count++;
            end
            if (rsp_bus.expr_done !== want.expr_done) begin
               $error("expr_done: expected %b, got %b", want.expr_done, rsp_bus.expr_done);
               fail_count++;
            end
            if (rsp_bus.error_code !== want.error_code) begin
               $error("error_code: expected %0d, got %0d", want.error_code,
                      rsp_bus.error_code);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("FAIL infix_to_postfix_converter");
         $finish;
      end
   end

endmodule
